### src/grl2x_pkg.sv
// ----------------------------------------------------------------------------
// grl2x_pkg
// Shared constants, types and codes of the two-times Lagrange grid refiner.
// ----------------------------------------------------------------------------
`default_nettype none

package grl2x_pkg;

	// Block dimensions.
	localparam int HALF_ORDER    = 3;
	localparam int MAX_FINE_SIDE = 256;
	localparam int SAMPLE_WIDTH  = 24;

	localparam int TAPS     = 2 * HALF_ORDER;
	localparam int CSIDE    = MAX_FINE_SIDE / 2 + TAPS - 1;
	localparam int ADDR_W   = $clog2(CSIDE * CSIDE);
	localparam int TAP_W    = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int NUM_COEF = 6;
	localparam int COEF_W   = 16;
	localparam int IDX_W    = 8;
	localparam int SIDE_W   = 9;

	// Weight is a product of two Q1.15 factors, so Q2.30.
	localparam int FRAC     = 30;
	localparam int FACT_W   = COEF_W + 1;
	localparam int WEIGHT_W = 32;
	localparam int PROD_W   = WEIGHT_W + SAMPLE_WIDTH;
	localparam int ACC_W    = PROD_W + 6;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_FINE_ROWS = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_FINE_COLS = 3'd7;

	// Operation carried from front to back.
	typedef enum logic [2:0] {
		OP_WRITE,
		OP_FAULT,
		OP_COPY,
		OP_VERT,
		OP_HORZ,
		OP_BOTH
	} op_t;

	// Back-end sequencer states.
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_DRAIN,
		BK_OUT
	} bk_state_t;

	// One queued item: a write, or a classified request with its base row and column.
	typedef struct packed {
		op_t                           op;
		logic [IDX_W-1:0]              row;
		logic [IDX_W-1:0]              col;
		logic signed [SAMPLE_WIDTH-1:0] data;
	} job_t;

	// Queue status: empty towards the back end, full towards the front.
	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	typedef logic [NUM_COEF-1:0][COEF_W-1:0] coef_vec_t;

endpackage

`default_nettype wire

### src/grl2x_front.sv
// ----------------------------------------------------------------------------
// grl2x_front
// Accepts items, drops writes outside the grid and classifies requests.
// ----------------------------------------------------------------------------
`default_nettype none

module grl2x_front (
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 req_type,
	input  wire logic [grl2x_pkg::IDX_W-1:0]          coarse_row,
	input  wire logic [grl2x_pkg::IDX_W-1:0]          coarse_col,
	input  wire logic signed [grl2x_pkg::SAMPLE_WIDTH-1:0] sample_value,
	input  wire logic [grl2x_pkg::IDX_W-1:0]          fine_row,
	input  wire logic [grl2x_pkg::IDX_W-1:0]          fine_col,
	input  wire logic [grl2x_pkg::SIDE_W-1:0]         fine_rows,
	input  wire logic [grl2x_pkg::SIDE_W-1:0]         fine_cols,
	input  wire grl2x_pkg::q_status_t                 q_status,
	output logic                                      push,
	output grl2x_pkg::job_t                           job
);
	import grl2x_pkg::*;

	logic [SIDE_W-1:0] rows, cols, crows, ccols;
	logic              wr_ok, fault;

	// Effective grid sizes.
	always_comb begin
		rows  = (fine_rows > SIDE_W'(MAX_FINE_SIDE)) ? SIDE_W'(MAX_FINE_SIDE) : fine_rows;
		cols  = (fine_cols > SIDE_W'(MAX_FINE_SIDE)) ? SIDE_W'(MAX_FINE_SIDE) : fine_cols;
		crows = {1'b0, rows[SIDE_W-1:1]} + SIDE_W'(TAPS - 1);
		ccols = {1'b0, cols[SIDE_W-1:1]} + SIDE_W'(TAPS - 1);
	end

	// Range checks.
	always_comb begin
		wr_ok = ({1'b0, coarse_row} < crows) && ({1'b0, coarse_col} < ccols)
			&& ({1'b0, coarse_row} < SIDE_W'(CSIDE)) && ({1'b0, coarse_col} < SIDE_W'(CSIDE));
		fault = ({1'b0, fine_row} >= rows) || ({1'b0, fine_col} >= cols);
	end

	assign in_ready = !q_status.full;
	assign push     = in_valid && in_ready && (req_type || wr_ok);

	// Classification; an odd index's stencil starts at base row fine_row/2.
	always_comb begin
		job.data = sample_value;
		if (!req_type) begin
			job.op  = OP_WRITE;
			job.row = coarse_row;
			job.col = coarse_col;
		end else begin
			job.row = fine_row[0] ? {1'b0, fine_row[IDX_W-1:1]}
				: {1'b0, fine_row[IDX_W-1:1]} + IDX_W'(HALF_ORDER - 1);
			job.col = fine_col[0] ? {1'b0, fine_col[IDX_W-1:1]}
				: {1'b0, fine_col[IDX_W-1:1]} + IDX_W'(HALF_ORDER - 1);
			if (fault)
				job.op = OP_FAULT;
			else if (fine_row[0] && fine_col[0])
				job.op = OP_BOTH;
			else if (fine_row[0])
				job.op = OP_VERT;
			else if (fine_col[0])
				job.op = OP_HORZ;
			else
				job.op = OP_COPY;
		end
	end

endmodule

`default_nettype wire

### src/grl2x_queue.sv
// ----------------------------------------------------------------------------
// grl2x_queue
// Four-entry item queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module grl2x_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire grl2x_pkg::job_t  push_job,
	input  wire logic             pop,
	output grl2x_pkg::job_t       head,
	output grl2x_pkg::q_status_t  q_status
);
	import grl2x_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	job_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign q_status.empty = (count_q == '0);
	assign q_status.full  = (count_q == (PTR_W+1)'(DEPTH));
	assign head           = slot_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_job;
	end

endmodule

`default_nettype wire

### src/grl2x_back.sv
// ----------------------------------------------------------------------------
// grl2x_back
// Coarse store and multiply-accumulate sequencer that carries out queued items.
// ----------------------------------------------------------------------------
`default_nettype none

module grl2x_back (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire grl2x_pkg::coef_vec_t                  coefs,
	input  wire grl2x_pkg::job_t                       head,
	input  wire grl2x_pkg::q_status_t                  q_status,
	output logic                                       pop,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [grl2x_pkg::SAMPLE_WIDTH-1:0]  fine_value,
	output logic                                       status
);
	import grl2x_pkg::*;

	localparam logic signed [FACT_W-1:0] ONE = FACT_W'(1 << (COEF_W - 1));
	localparam logic signed [ACC_W-1:0]  HALF_LSB = ACC_W'(64'sd1 <<< (FRAC - 1));
	localparam logic signed [ACC_W-1:0]  SAT_HI = ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1);
	localparam logic signed [ACC_W-1:0]  SAT_LO = ACC_W'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

	bk_state_t state_q, state_d;

	// Current job.
	logic             row_it_q, col_it_q;
	logic [IDX_W-1:0] row0_q, col0_q;
	logic [TAP_W-1:0] k_q, l_q;
	logic             last_tap, issue;

	// Pipeline.
	logic                           valid_s1, valid_s2, valid_s3;
	logic [ADDR_W-1:0]              addr_s1;
	logic signed [FACT_W-1:0]       fa_s1, fb_s1;
	logic signed [WEIGHT_W-1:0]     weight_s2;
	logic signed [SAMPLE_WIDTH-1:0] rdata_s2;
	logic signed [PROD_W-1:0]       prod_s3;
	logic signed [ACC_W-1:0]        acc_q;

	logic signed [SAMPLE_WIDTH-1:0] mem [CSIDE * CSIDE];

	logic                           mem_we;
	logic [ADDR_W-1:0]              waddr, raddr;
	logic [IDX_W-1:0]               row_c, col_c;
	logic signed [FACT_W-1:0]       fa_c, fb_c;
	logic signed [ACC_W-1:0]        rounded, shifted;
	logic signed [SAMPLE_WIDTH-1:0] result_q;
	logic                           fault_q;
	logic                           pipe_empty;

	assign pipe_empty = !valid_s1 && !valid_s2 && !valid_s3;
	assign last_tap   = (!row_it_q || (k_q == TAP_W'(TAPS - 1)))
		&& (!col_it_q || (l_q == TAP_W'(TAPS - 1)));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!q_status.empty && (head.op != OP_WRITE))
					state_d = (head.op == OP_FAULT) ? BK_OUT : BK_RUN;
			end
			BK_RUN: begin
				if (last_tap)
					state_d = BK_DRAIN;
			end
			BK_DRAIN: begin
				if (pipe_empty)
					state_d = BK_OUT;
			end
			BK_OUT: begin
				if (out_ready)
					state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		pop       = (state_q == BK_IDLE) && !q_status.empty;
		issue     = (state_q == BK_RUN);
		out_valid = (state_q == BK_OUT);
		mem_we    = pop && (head.op == OP_WRITE);
	end

	// Tap address and factors.
	always_comb begin
		row_c = row0_q + (row_it_q ? IDX_W'(k_q) : '0);
		col_c = col0_q + (col_it_q ? IDX_W'(l_q) : '0);
		raddr = ADDR_W'(ADDR_W'(row_c) * ADDR_W'(CSIDE)) + ADDR_W'(col_c);
		waddr = ADDR_W'(ADDR_W'(head.row) * ADDR_W'(CSIDE)) + ADDR_W'(head.col);
		fa_c  = row_it_q ? FACT_W'($signed(coefs[k_q])) : ONE;
		fb_c  = col_it_q ? FACT_W'($signed(coefs[l_q])) : ONE;
	end

	// Round half up at the Q2.30 point; saturation follows in the datapath registers.
	always_comb begin
		rounded = acc_q + HALF_LSB;
		shifted = rounded >>> FRAC;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			k_q      <= '0;
			l_q      <= '0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			if (pop) begin
				k_q <= '0;
				l_q <= '0;
			end else if (issue) begin
				if (col_it_q && (l_q != TAP_W'(TAPS - 1))) begin
					l_q <= l_q + 1'b1;
				end else begin
					l_q <= '0;
					if (row_it_q)
						k_q <= k_q + 1'b1;
				end
			end
		end
	end

	// Job and datapath registers.
	always_ff @(posedge clk) begin
		if (pop) begin
			row0_q   <= head.row;
			col0_q   <= head.col;
			row_it_q <= (head.op == OP_VERT) || (head.op == OP_BOTH);
			col_it_q <= (head.op == OP_HORZ) || (head.op == OP_BOTH);
			fault_q  <= (head.op == OP_FAULT);
			acc_q    <= '0;
			result_q <= '0;
		end else begin
			if (valid_s3)
				acc_q <= acc_q + ACC_W'(prod_s3);
			if ((state_q == BK_DRAIN) && pipe_empty) begin
				if (shifted > SAT_HI)
					result_q <= SAT_HI[SAMPLE_WIDTH-1:0];
				else if (shifted < SAT_LO)
					result_q <= SAT_LO[SAMPLE_WIDTH-1:0];
				else
					result_q <= shifted[SAMPLE_WIDTH-1:0];
			end
		end
		addr_s1   <= raddr;
		fa_s1     <= fa_c;
		fb_s1     <= fb_c;
		weight_s2 <= WEIGHT_W'(fa_s1 * fb_s1);
		prod_s3   <= weight_s2 * rdata_s2;
	end

	// Coarse store: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[waddr] <= head.data;
		rdata_s2 <= mem[addr_s1];
	end

	assign fine_value = result_q;
	assign status     = fault_q;

endmodule

`default_nettype wire

### src/grid_refine_lagrange_2x_unit.sv
// ----------------------------------------------------------------------------
// grid_refine_lagrange_2x_unit
// Two-times Lagrange upsampling of a padded coarse grid held in local memory.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                                             Direction
//  in       in_valid/in_ready, req_type, coarse_*, sample_value, fine_*  in
//  out      out_valid/out_ready, fine_value, status              out
//  cfg      cfg_we, cfg_index, cfg_data                         in
//
// A write is stored in the coarse store as it leaves the queue. A request
// leaves the queue, then makes 1, 6 or 36 memory reads, one per cycle through
// the single read port, waits for the pipeline to drain and then presents its
// result, which holds while the output is stalled. An out-of-range request
// goes straight to the output with no reads. Reset clears control state only;
// the coarse store is undefined until written.
// A four-item queue lets the front keep accepting while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_refine_lagrange_2x_unit (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [grl2x_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [grl2x_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic                                  req_type,
	input  wire logic [grl2x_pkg::IDX_W-1:0]           coarse_row,
	input  wire logic [grl2x_pkg::IDX_W-1:0]           coarse_col,
	input  wire logic signed [grl2x_pkg::SAMPLE_WIDTH-1:0] sample_value,
	input  wire logic [grl2x_pkg::IDX_W-1:0]           fine_row,
	input  wire logic [grl2x_pkg::IDX_W-1:0]           fine_col,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [grl2x_pkg::SAMPLE_WIDTH-1:0]  fine_value,
	output logic                                       status
);
	import grl2x_pkg::*;

	localparam logic [NUM_COEF-1:0][COEF_W-1:0] COEF_RESET = {
		16'sd384, -16'sd3200, 16'sd19200, 16'sd19200, -16'sd3200, 16'sd384
	};

	coef_vec_t         coefs_q;
	logic [SIDE_W-1:0] fine_rows_q, fine_cols_q;
	q_status_t         q_status;
	logic              push, pop;
	job_t              push_job, head;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q     <= COEF_RESET;
			fine_rows_q <= SIDE_W'(MAX_FINE_SIDE);
			fine_cols_q <= SIDE_W'(MAX_FINE_SIDE);
		end else if (cfg_we) begin
			if (cfg_index == CFG_FINE_ROWS)
				fine_rows_q <= cfg_data[SIDE_W-1:0];
			else if (cfg_index == CFG_FINE_COLS)
				fine_cols_q <= cfg_data[SIDE_W-1:0];
			else
				coefs_q[cfg_index] <= cfg_data[COEF_W-1:0];
		end
	end

	grl2x_front u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.coarse_row   (coarse_row),
		.coarse_col   (coarse_col),
		.sample_value (sample_value),
		.fine_row     (fine_row),
		.fine_col     (fine_col),
		.fine_rows    (fine_rows_q),
		.fine_cols    (fine_cols_q),
		.q_status     (q_status),
		.push         (push),
		.job          (push_job)
	);

	grl2x_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.q_status (q_status)
	);

	grl2x_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.coefs      (coefs_q),
		.head       (head),
		.q_status   (q_status),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.fine_value (fine_value),
		.status     (status)
	);

endmodule

`default_nettype wire

### src/grl2x_checker.sv
// ----------------------------------------------------------------------------
// grl2x_checker
// Port-level checks of the grid refiner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module grl2x_checker (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  in_valid,
	input wire logic                                  in_ready,
	input wire logic                                  req_type,
	input wire logic                                  out_valid,
	input wire logic                                  out_ready,
	input wire logic signed [grl2x_pkg::SAMPLE_WIDTH-1:0] fine_value,
	input wire logic                                  status
);
	import grl2x_pkg::*;

	logic [7:0] pending_q;
	logic       req_acc, out_acc;

	assign req_acc = in_valid && in_ready && req_type;
	assign out_acc = out_valid && out_ready;

	// Requests accepted and not yet answered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pending_q <= '0;
		else if (req_acc && !out_acc)
			pending_q <= pending_q + 1'b1;
		else if (out_acc && !req_acc)
			pending_q <= pending_q - 1'b1;
	end

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fine_value) && $stable(status))
		else $error("result changed while stalled");

	// An out-of-range answer carries a zero value.
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> fine_value == '0)
		else $error("fault result with non-zero value");

	// No result without an outstanding request.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("result without request");

endmodule

bind grid_refine_lagrange_2x_unit grl2x_checker u_grl2x_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.req_type   (req_type),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.fine_value (fine_value),
	.status     (status)
);

`default_nettype wire
